// ===== src/mclp_pkg.sv =====
// ---------------------------------------------------------------------------
// mclp_pkg
// Shared types and constants for the multi-click / long-press decoder.
// ---------------------------------------------------------------------------
package mclp_pkg;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_CLICK_WINDOW    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS_STEP = 1'd1;

  // register reset values
  localparam logic [15:0] CLICK_WINDOW_RST    = 16'd200;
  localparam logic [7:0]  BRIGHTNESS_STEP_RST = 8'd10;

  // brightness end stops and click saturation
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] CLICK_MAX = 8'd255;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 2;

  // one result beat
  typedef struct packed {
    logic       clicks_ready;
    logic [7:0] click_count;
    logic       brightness_write;
    logic [7:0] new_brightness;
  } mclp_res_t;

endpackage

// ===== src/mclp_core.sv =====
// ---------------------------------------------------------------------------
// mclp_core
// Button state, click counting, window timing and brightness ramp.
// Result is combinational from the accepted beat and the current state.
// ---------------------------------------------------------------------------
module mclp_core
  import mclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat,
  input  logic        func,
  input  logic        button_pressed,
  input  logic [31:0] now_ms,
  input  logic [7:0]  current_brightness,
  input  logic [15:0] click_window_ms,
  input  logic [7:0]  brightness_step,
  output mclp_res_t   res
);

  logic        last_level_r,     last_level_nxt;
  logic [31:0] last_edge_time_r, last_edge_time_nxt;
  logic [7:0]  click_counter_r,  click_counter_nxt;
  logic        window_running_r, window_running_nxt;
  logic [31:0] window_start_r,   window_start_nxt;
  logic        ramp_up_r,        ramp_up_nxt;

  logic [31:0] held;
  logic [31:0] since_start;
  logic [31:0] win_ext;
  logic        exp_before;
  logic        restart;
  logic        exp_after;
  logic [7:0]  cnt_edge;
  logic [8:0]  ramp_sum;

  assign win_ext     = {16'd0, click_window_ms};
  assign held        = now_ms - last_edge_time_r;
  assign since_start = now_ms - window_start_r;
  assign exp_before  = window_running_r && (since_start >= win_ext);
  assign ramp_sum    = {1'b0, current_brightness} + {1'b0, brightness_step};

  // edge handling, then expiry action on the settled level
  always_comb begin
    last_level_nxt     = last_level_r;
    last_edge_time_nxt = last_edge_time_r;
    window_running_nxt = window_running_r;
    window_start_nxt   = window_start_r;
    ramp_up_nxt        = ramp_up_r;
    cnt_edge           = click_counter_r;
    restart            = 1'b0;
    res                = '0;

    if (func) begin
      if (last_level_r && !button_pressed) begin
        // release ending a press: short click, stale sequence cleared
        if ((held < win_ext) && (click_counter_r < CLICK_MAX)) begin
          cnt_edge = click_counter_r + 8'd1;
        end
        if (exp_before) begin
          cnt_edge = '0;
        end
        restart = 1'b1;
      end else if (button_pressed) begin
        restart = 1'b1;
      end
      last_level_nxt     = button_pressed;
      last_edge_time_nxt = now_ms;
    end

    if (restart) begin
      window_running_nxt = 1'b1;
      window_start_nxt   = now_ms;
    end

    // a restarted window has zero elapsed time
    exp_after = restart ? (click_window_ms == 16'd0) : exp_before;

    click_counter_nxt = cnt_edge;
    if (exp_after) begin
      if (!last_level_nxt) begin
        if (cnt_edge != 8'd0) begin
          res.clicks_ready = 1'b1;
          res.click_count  = cnt_edge;
        end
        click_counter_nxt = '0;
      end else if (cnt_edge == 8'd0) begin
        // hold repeat: ramp and bounce at the ends
        res.brightness_write = 1'b1;
        if (!ramp_up_r) begin
          if (brightness_step > current_brightness) begin
            res.new_brightness = '0;
            ramp_up_nxt        = 1'b1;
          end else begin
            res.new_brightness = current_brightness - brightness_step;
          end
        end else begin
          if ((LEVEL_MAX - brightness_step) < current_brightness) begin
            res.new_brightness = LEVEL_MAX;
            ramp_up_nxt        = 1'b0;
          end else begin
            res.new_brightness = ramp_sum[7:0];
          end
        end
      end
    end
  end

  // state registers, updated per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r     <= 1'b0;
      last_edge_time_r <= '0;
      click_counter_r  <= '0;
      window_running_r <= 1'b0;
      window_start_r   <= '0;
      ramp_up_r        <= 1'b0;
    end else if (beat) begin
      last_level_r     <= last_level_nxt;
      last_edge_time_r <= last_edge_time_nxt;
      click_counter_r  <= click_counter_nxt;
      window_running_r <= window_running_nxt;
      window_start_r   <= window_start_nxt;
      ramp_up_r        <= ramp_up_nxt;
    end
  end

endmodule

// ===== src/mclp_obuf.sv =====
// ---------------------------------------------------------------------------
// mclp_obuf
// Two-entry result buffer: output register plus skid stage, so a new beat
// is taken while a finished result is still held by the receiver.
// ---------------------------------------------------------------------------
module mclp_obuf
  import mclp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  mclp_res_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output mclp_res_t rd_data
);

  mclp_res_t main_r, main_nxt;
  mclp_res_t skid_r, skid_nxt;
  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  logic      wr_fire;
  logic      rd_fire;

  assign wr_ready = !skid_vld_r;
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = main_vld_r && rd_ready;
  assign rd_valid = main_vld_r;
  assign rd_data  = main_r;

  // next-state of the two entries
  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (rd_fire) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (wr_fire) begin
        main_nxt = wr_data;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (wr_fire) begin
      if (!main_vld_r) begin
        main_nxt     = wr_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = wr_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== src/multi_click_long_press_decoder.sv =====
// ---------------------------------------------------------------------------
// multi_click_long_press_decoder
// Decodes time-stamped button beats into multi-click reports and a
// hold-to-ramp brightness value.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one beat per button level change (tuser = 1) or poll
//   (tuser = 0), each carrying a millisecond timestamp and the brightness
//   in effect. Every input beat yields exactly one output beat.
//   Output stream: tuser flags a click report or a brightness write;
//   tdata holds the click count and the ramped brightness.
//   Config: click window (index 0) and ramp step (index 1) are to be written
//   only while the block is idle; the block itself does not enforce this.
//   Throughput is one beat per cycle while in_tready is high. The state
//   update and result for a beat are computed combinationally from the
//   beat and the stored state (two 32-bit time subtracts and compares set
//   the path) and land in the output register or the skid entry. A two-entry
//   output buffer keeps in_tready high while one result waits; in_tready
//   drops only when both entries are full.
//   Reset (synchronous, rst_n low) clears button state, counters, ramp
//   direction and buffered results, and loads the register defaults
//   (200 ms window, step 10).
// ---------------------------------------------------------------------------
module multi_click_long_press_decoder
  import mclp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // button_pressed, now_ms[31:0],
                                             // current_brightness[7:0], zero pad
  input  logic [IN_TUSER_W-1:0] in_tuser,   // func
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // click_count[7:0], new_brightness[7:0]
  output logic [OUT_TUSER_W-1:0] out_tuser, // clicks_ready, brightness_write
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] click_window_r;
  logic [7:0]  brightness_step_r;
  logic        in_beat;
  mclp_res_t   core_res;
  mclp_res_t   out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_window_r    <= CLICK_WINDOW_RST;
      brightness_step_r <= BRIGHTNESS_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CLICK_WINDOW:    click_window_r    <= cfg_wdata;
        REG_BRIGHTNESS_STEP: brightness_step_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_beat = in_tvalid && in_tready;

  mclp_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .beat               (in_beat),
    .func               (in_tuser[0]),
    .button_pressed     (in_tdata[0]),
    .now_ms             (in_tdata[32:1]),
    .current_brightness (in_tdata[40:33]),
    .click_window_ms    (click_window_r),
    .brightness_step    (brightness_step_r),
    .res                (core_res)
  );

  mclp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (core_res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_res)
  );

  assign out_tdata = {out_res.new_brightness, out_res.click_count};
  assign out_tuser = {out_res.brightness_write, out_res.clicks_ready};

  // ---- assertions ----

  // a full buffer always has a result on offer
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // report needs a released button, ramp a held one
  a_report_xor_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("click report and brightness write together");

  // a report carries a nonzero count, and only a report does
  a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[7:0] != 8'd0)))
    else $error("click count disagrees with report flag");

  // nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule
